[hdl/clnw_pkg.sv]
// clnw_pkg: shared types, constants and word helpers for the character lcd
// nibble writer. No dependencies; used by the interfaces and the top level.
package clnw_pkg;

    // display geometry and cache size
    localparam int COLUMNS     = 16;
    localparam int CACHE_DEPTH = 32;
    localparam int CACHE_AW    = $clog2(CACHE_DEPTH);
    localparam int POS_W       = $clog2(COLUMNS + 1);
    localparam int CNT_W       = 5;

    // payload field widths
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int COL_W   = 4;
    localparam int INDEX_W = 5;

    // lcd instruction codes
    localparam logic [7:0] LCD_LINE0_ADDR = 8'h80;
    localparam logic [7:0] LCD_LINE1_ADDR = 8'hC0;
    localparam logic [7:0] LCD_ADDR_MASK  = 8'h7F;
    localparam logic [7:0] LCD_SHIFT      = 8'h10;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0E;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [3:0] LCD_WAKE_NIB   = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB   = 4'h2;

    // cache fill patterns
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // result counts (index of the final word)
    localparam logic [CNT_W-1:0] LAST_BYTE   = CNT_W'(3);
    localparam logic [CNT_W-1:0] LAST_2BYTE  = CNT_W'(7);
    localparam logic [CNT_W-1:0] LAST_INIT   = CNT_W'(23);
    localparam logic [CNT_W-1:0] LAST_SINGLE = CNT_W'(0);
    localparam int INIT_NIBBLE_WORDS = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR   = 3'd0,
        OP_INSTR  = 3'd1,
        OP_SETCUR = 3'd2,
        OP_SHIFT  = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_INIT   = 3'd5,
        OP_READ   = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        SEQ_BYTES,
        SEQ_INIT,
        SEQ_READ
    } t_seq;

    // shift register word: nibble, two spare zeros, enable, register select
    function automatic logic [7:0] sr_word(input logic [3:0] nib, input logic en,
                                           input logic rs);
        sr_word = {nib, 2'b00, en, rs};
    endfunction

    // word k of a byte sent as two nibbles, each with enable high then low
    function automatic logic [7:0] byte_word(input logic [7:0] b, input logic [1:0] k,
                                             input logic rs);
        logic [3:0] nib;
        nib = k[1] ? b[3:0] : b[7:4];
        byte_word = sr_word(nib, ~k[0], rs);
    endfunction

    // set-address instruction for a line and column
    function automatic logic [7:0] addr_byte(input logic ln, input logic [POS_W-1:0] col);
        addr_byte = (ln ? LCD_LINE1_ADDR : LCD_LINE0_ADDR) | (8'(col) & LCD_ADDR_MASK);
    endfunction

    // power-up sequence: four single nibbles then four instructions
    function automatic logic [7:0] init_word(input logic [CNT_W-1:0] k);
        logic [CNT_W-1:0] j;
        logic [7:0]       b;
        j = k - CNT_W'(INIT_NIBBLE_WORDS);
        case (j[3:2])
            2'd0:    b = LCD_FUNC_SET;
            2'd1:    b = LCD_DISP_ON;
            2'd2:    b = LCD_CLEAR;
            default: b = LCD_ENTRY_MODE;
        endcase
        if (k < CNT_W'(INIT_NIBBLE_WORDS - 2)) begin
            init_word = sr_word(LCD_WAKE_NIB, ~k[0], 1'b0);
        end else if (k < CNT_W'(INIT_NIBBLE_WORDS)) begin
            init_word = sr_word(LCD_4BIT_NIB, ~k[0], 1'b0);
        end else begin
            init_word = byte_word(b, j[1:0], 1'b0);
        end
    endfunction

endpackage

[hdl/clnw_cmd_if.sv]
// clnw_cmd_if: command channel of the nibble writer, valid/ready handshake
// depends on clnw_pkg for field widths
interface clnw_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [clnw_pkg::OP_W-1:0]       operation;
    logic [clnw_pkg::BYTE_W-1:0]     value;
    logic                            line;
    logic [clnw_pkg::COL_W-1:0]      column;
    logic                            direction;
    logic [clnw_pkg::INDEX_W-1:0]    index;

    modport source (output valid, operation, value, line, column, direction, index,
                    input ready);
    modport sink   (input valid, operation, value, line, column, direction, index,
                    output ready);
endinterface

[hdl/clnw_out_if.sv]
// clnw_out_if: result channel of the nibble writer, valid/ready handshake
// depends on clnw_pkg for field widths
interface clnw_out_if;
    logic                        valid;
    logic                        ready;
    logic [clnw_pkg::BYTE_W-1:0] sr_byte;
    logic                        sr_valid;
    logic [clnw_pkg::BYTE_W-1:0] read_char;
    logic                        last;

    modport source (output valid, sr_byte, sr_valid, read_char, last, input ready);
    modport sink   (input valid, sr_byte, sr_valid, read_char, last, output ready);
endinterface

[hdl/char_lcd_nibble_writer.sv]
// char_lcd_nibble_writer: 4-bit lcd command sequencer with a character cache
// depends on clnw_pkg, clnw_cmd_if and clnw_out_if
//
// Usage: commands arrive on i_cmd (char, instruction, set cursor, shift cursor,
// clear, init, read cache). Each accepted command yields its result words on
// o_res, one per cycle while the receiver is ready, the final one flagged by
// last. Shift register words carry sr_valid = 1; a read cache command yields a
// single word with sr_valid = 0 and the cached character in read_char.
// The command is registered into the word sequencer, which then loads its
// first word into the output register. Throughput: one word per cycle while
// the receiver is ready, set by the single word sequencer; a command has 1 word
// for a read, 4 for most, 8 for a char that wraps the line, 24 for init.
// The next command is taken in the cycle the previous one's final word is
// generated, so commands stream without gaps. Code 7 is taken and dropped.
// The cache is a 32 x 8 synchronous memory, one write or one read a cycle, with
// a valid bit per entry; clear and init drop all valid bits and set the fill
// character, so they take no sweep.
// Reset: cursor at line 0 column 0, cache reads as spaces, no words pending.
// A stalled receiver holds the output register and stops the sequencer, which
// in turn holds off new commands.
module char_lcd_nibble_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clnw_cmd_if.sink          i_cmd,
    clnw_out_if.source        o_res
);

    localparam int PW = clnw_pkg::POS_W;
    localparam int AW = clnw_pkg::CACHE_AW;
    localparam int CW = clnw_pkg::CNT_W;

    // cursor and cache bookkeeping
    logic                   r_line;
    logic [PW-1:0]          r_pos;
    logic [clnw_pkg::CACHE_DEPTH-1:0] r_valid;
    logic [7:0]             r_fill;
    logic [7:0]             r_cache [clnw_pkg::CACHE_DEPTH];
    logic [7:0]             r_rd_data;
    logic                   r_rd_hit;
    logic                   r_rd_inrange;
    logic [7:0]             r_rd_fill;

    // word sequencer
    logic                   r_g_active;
    clnw_pkg::t_seq         r_g_kind;
    logic                   r_g_has_pre;
    logic [7:0]             r_g_pre;
    logic [7:0]             r_g_main;
    logic                   r_g_rs;
    logic [CW-1:0]          r_g_cnt;
    logic [CW-1:0]          r_g_last;

    // output register
    logic                   r_o_valid;
    logic [7:0]             r_o_byte;
    logic                   r_o_srv;
    logic [7:0]             r_o_char;
    logic                   r_o_last;

    // next values decoded from the command
    logic                   n_line;
    logic [PW-1:0]          n_pos;
    logic                   n_start;
    clnw_pkg::t_seq         n_kind;
    logic                   n_has_pre;
    logic [7:0]             n_pre;
    logic [7:0]             n_main;
    logic                   n_rs;
    logic [CW-1:0]          n_last;
    logic                   n_wr;
    logic [AW-1:0]          n_wr_addr;
    logic                   n_clr;
    logic                   n_ini;
    logic                   n_rd;

    logic                   cmd_fire;
    logic                   out_load;
    logic                   gen_fire;
    logic                   gen_done;
    logic [7:0]             g_byte;
    logic                   g_srv;
    logic [7:0]             g_char;
    logic [PW:0]            shift_np;
    logic [PW-1:0]          set_col;

    // handshake
    assign out_load    = ~r_o_valid | o_res.ready;
    assign gen_fire    = r_g_active & out_load;
    assign gen_done    = gen_fire & (r_g_cnt == r_g_last);
    assign i_cmd.ready = ~r_g_active | gen_done;
    assign cmd_fire    = i_cmd.valid & i_cmd.ready;

    assign o_res.valid     = r_o_valid;
    assign o_res.sr_byte   = r_o_byte;
    assign o_res.sr_valid  = r_o_srv;
    assign o_res.read_char = r_o_char;
    assign o_res.last      = r_o_last;

    // command decode: cursor update, cache access and word plan
    always_comb begin
        n_line    = r_line;
        n_pos     = r_pos;
        n_start   = 1'b1;
        n_kind    = clnw_pkg::SEQ_BYTES;
        n_has_pre = 1'b0;
        n_pre     = 8'h00;
        n_main    = i_cmd.value;
        n_rs      = 1'b0;
        n_last    = clnw_pkg::LAST_BYTE;
        n_wr      = 1'b0;
        n_wr_addr = '0;
        n_clr     = 1'b0;
        n_ini     = 1'b0;
        n_rd      = 1'b0;
        shift_np  = i_cmd.direction ? ({1'b0, r_pos} + (PW+1)'(1))
                                    : ({1'b0, r_pos} - (PW+1)'(1));
        set_col   = (PW'(i_cmd.column) > PW'(clnw_pkg::COLUMNS - 1))
                    ? PW'(clnw_pkg::COLUMNS - 1) : PW'(i_cmd.column);
        case (clnw_pkg::t_op'(i_cmd.operation))
            clnw_pkg::OP_CHAR: begin
                if (r_pos >= PW'(clnw_pkg::COLUMNS)) begin
                    n_has_pre = 1'b1;
                    n_pre     = clnw_pkg::addr_byte(~r_line, '0);
                    n_line    = ~r_line;
                    n_last    = clnw_pkg::LAST_2BYTE;
                    n_wr_addr = AW'(32'({~r_line}) * clnw_pkg::COLUMNS);
                    n_pos     = PW'(1);
                end else begin
                    n_wr_addr = AW'(32'(r_line) * clnw_pkg::COLUMNS + 32'(r_pos));
                    n_pos     = r_pos + PW'(1);
                end
                n_wr = 1'b1;
                n_rs = 1'b1;
            end
            clnw_pkg::OP_INSTR: begin
                n_main = i_cmd.value;
            end
            clnw_pkg::OP_SETCUR: begin
                n_main = clnw_pkg::addr_byte(i_cmd.line, set_col);
                n_line = i_cmd.line;
                n_pos  = set_col;
            end
            clnw_pkg::OP_SHIFT: begin
                if (!i_cmd.direction && r_pos == '0) begin
                    n_main = clnw_pkg::addr_byte(~r_line, PW'(clnw_pkg::COLUMNS - 1));
                    n_line = ~r_line;
                    n_pos  = PW'(clnw_pkg::COLUMNS - 1);
                end else if (shift_np >= (PW+1)'(clnw_pkg::COLUMNS)) begin
                    n_main = clnw_pkg::addr_byte(~r_line, '0);
                    n_line = ~r_line;
                    n_pos  = '0;
                end else begin
                    n_main = clnw_pkg::LCD_SHIFT | {5'b0, i_cmd.direction, 2'b00};
                    n_pos  = shift_np[PW-1:0];
                end
            end
            clnw_pkg::OP_CLEAR: begin
                n_main = clnw_pkg::LCD_CLEAR;
                n_line = 1'b0;
                n_pos  = '0;
                n_clr  = 1'b1;
            end
            clnw_pkg::OP_INIT: begin
                n_kind = clnw_pkg::SEQ_INIT;
                n_last = clnw_pkg::LAST_INIT;
                n_line = 1'b0;
                n_pos  = '0;
                n_ini  = 1'b1;
            end
            clnw_pkg::OP_READ: begin
                n_kind = clnw_pkg::SEQ_READ;
                n_last = clnw_pkg::LAST_SINGLE;
                n_rd   = 1'b1;
            end
            default: begin
                n_start = 1'b0;
            end
        endcase
    end

    // current word of the sequencer
    always_comb begin
        g_srv  = 1'b1;
        g_char = 8'h00;
        case (r_g_kind)
            clnw_pkg::SEQ_BYTES: begin
                if (r_g_has_pre && !r_g_cnt[2]) begin
                    g_byte = clnw_pkg::byte_word(r_g_pre, r_g_cnt[1:0], 1'b0);
                end else begin
                    g_byte = clnw_pkg::byte_word(r_g_main, r_g_cnt[1:0], r_g_rs);
                end
            end
            clnw_pkg::SEQ_INIT: begin
                g_byte = clnw_pkg::init_word(r_g_cnt);
            end
            clnw_pkg::SEQ_READ: begin
                g_byte = 8'h00;
                g_srv  = 1'b0;
                if (r_rd_inrange) begin
                    g_char = r_rd_hit ? r_rd_data : r_rd_fill;
                end
            end
            default: begin
                g_byte = 8'h00;
            end
        endcase
    end

    // cache memory: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (cmd_fire && n_wr) begin
            r_cache[n_wr_addr] <= i_cmd.value;
        end
        if (cmd_fire && n_rd) begin
            r_rd_data <= r_cache[i_cmd.index[AW-1:0]];
        end
    end

    // control state, cursor, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= 1'b0;
            r_pos      <= '0;
            r_valid    <= '0;
            r_fill     <= clnw_pkg::CHAR_SPACE;
            r_g_active <= 1'b0;
            r_g_cnt    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // command transaction
            if (cmd_fire) begin
                r_line <= n_line;
                r_pos  <= n_pos;
                if (n_wr) begin
                    r_valid[n_wr_addr] <= 1'b1;
                end
                if (n_clr) begin
                    r_valid <= '0;
                    r_fill  <= clnw_pkg::CHAR_NUL;
                end
                if (n_ini) begin
                    r_valid <= '0;
                    r_fill  <= clnw_pkg::CHAR_SPACE;
                end
                if (n_rd) begin
                    r_rd_hit     <= r_valid[i_cmd.index[AW-1:0]];
                    r_rd_inrange <= 32'(i_cmd.index) < clnw_pkg::CACHE_DEPTH;
                    r_rd_fill    <= r_fill;
                end
                r_g_active  <= n_start;
                r_g_kind    <= n_kind;
                r_g_has_pre <= n_has_pre;
                r_g_pre     <= n_pre;
                r_g_main    <= n_main;
                r_g_rs      <= n_rs;
                r_g_last    <= n_last;
                r_g_cnt     <= '0;
            end else if (gen_done) begin
                r_g_active <= 1'b0;
            end else if (gen_fire) begin
                r_g_cnt <= r_g_cnt + CW'(1);
            end

            // output register
            if (gen_fire) begin
                r_o_valid <= 1'b1;
                r_o_byte  <= g_byte;
                r_o_srv   <= g_srv;
                r_o_char  <= g_char;
                r_o_last  <= (r_g_cnt == r_g_last);
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

endmodule

[tb/tb_char_lcd_nibble_writer.sv]
// tb_char_lcd_nibble_writer: self-checking bench for the lcd nibble writer;
// predicts every shift register word and cache read from its own cursor/cache copy
// depends on clnw_pkg, clnw_cmd_if, clnw_out_if and char_lcd_nibble_writer
module tb_char_lcd_nibble_writer;
    import clnw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 90;
    localparam int IDLE_PCT     = 36;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic [OP_W-1:0]    operation;
        logic [BYTE_W-1:0]  value;
        logic               line;
        logic [COL_W-1:0]   column;
        logic               direction;
        logic [INDEX_W-1:0] index;
    } lcd_cmd_t;

    typedef struct {
        logic [7:0] sr_byte;
        logic       sr_valid;
        logic [7:0] read_char;
        logic       last;
    } lcd_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    clnw_cmd_if cmd_ch ();
    clnw_out_if res_ch ();

    char_lcd_nibble_writer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // predicted display state
    logic [7:0] lcd_text [CACHE_DEPTH];
    logic       cur_line;
    logic [4:0] cur_col;

    lcd_word_t expected_words[$];
    lcd_word_t want;
    int        errors       = 0;
    int        stall_cycles = 0;
    int        hold_req     = 0;
    int        hold_left    = 0;
    bit        steady       = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function void queue_word(input logic [7:0] w);
        lcd_word_t e;
        e.sr_byte   = w;
        e.sr_valid  = 1'b1;
        e.read_char = 8'h00;
        e.last      = 1'b0;
        expected_words.push_back(e);
    endfunction

    // each nibble goes out with enable high, then low
    function void queue_nibble(input logic [3:0] nib, input logic rs);
        queue_word({nib, 2'b00, 1'b1, rs});
        queue_word({nib, 2'b00, 1'b0, rs});
    endfunction

    function void queue_byte(input logic [7:0] b, input logic rs);
        queue_nibble(b[7:4], rs);
        queue_nibble(b[3:0], rs);
    endfunction

    function void jump_cursor(input logic ln, input logic [4:0] col);
        cur_line = ln;
        cur_col  = col;
        queue_byte((ln ? LCD_LINE1_ADDR : LCD_LINE0_ADDR) | (8'(col) & LCD_ADDR_MASK), 1'b0);
    endfunction

    function void fill_text(input logic [7:0] ch);
        int k;
        for (k = 0; k < CACHE_DEPTH; k++) lcd_text[k] = ch;
        cur_line = 1'b0;
        cur_col  = '0;
    endfunction

    // expected words of one accepted command, last flag on the final one
    function void predict_lcd(input lcd_cmd_t c);
        int        n0;
        int        slot;
        lcd_word_t w;
        n0 = expected_words.size();
        case (c.operation)
            OP_CHAR: begin
                if (cur_col >= COLUMNS) jump_cursor(~cur_line, 5'd0);
                slot = int'(cur_line) * COLUMNS + int'(cur_col);
                if (slot < CACHE_DEPTH) lcd_text[slot] = c.value;
                queue_byte(c.value, 1'b1);
                cur_col = cur_col + 5'd1;
            end
            OP_INSTR: queue_byte(c.value, 1'b0);
            OP_SETCUR: begin
                if (int'(c.column) > COLUMNS - 1) jump_cursor(c.line, 5'(COLUMNS - 1));
                else jump_cursor(c.line, {1'b0, c.column});
            end
            OP_SHIFT: begin
                if (!c.direction && cur_col == 0) begin
                    jump_cursor(~cur_line, 5'(COLUMNS - 1));
                end else if (c.direction && int'(cur_col) + 1 >= COLUMNS) begin
                    jump_cursor(~cur_line, 5'd0);
                end else begin
                    cur_col = c.direction ? cur_col + 5'd1 : cur_col - 5'd1;
                    queue_byte(LCD_SHIFT | {5'b0, c.direction, 2'b00}, 1'b0);
                end
            end
            OP_CLEAR: begin
                queue_byte(LCD_CLEAR, 1'b0);
                fill_text(CHAR_NUL);
            end
            OP_INIT: begin
                fill_text(CHAR_SPACE);
                queue_nibble(LCD_WAKE_NIB, 1'b0);
                queue_nibble(LCD_WAKE_NIB, 1'b0);
                queue_nibble(LCD_WAKE_NIB, 1'b0);
                queue_nibble(LCD_4BIT_NIB, 1'b0);
                queue_byte(LCD_FUNC_SET, 1'b0);
                queue_byte(LCD_DISP_ON, 1'b0);
                queue_byte(LCD_CLEAR, 1'b0);
                queue_byte(LCD_ENTRY_MODE, 1'b0);
            end
            OP_READ: begin
                w.sr_byte   = 8'h00;
                w.sr_valid  = 1'b0;
                w.read_char = (int'(c.index) < CACHE_DEPTH) ? lcd_text[c.index] : 8'h00;
                w.last      = 1'b0;
                expected_words.push_back(w);
            end
            default: ;  // unused code is dropped
        endcase
        if (expected_words.size() > n0) begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    // ---------------- stimulus ----------------

    // one command transaction; called and returns just after a falling edge
    task automatic send_cmd(input lcd_cmd_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= c.operation;
        cmd_ch.value     <= c.value;
        cmd_ch.line      <= c.line;
        cmd_ch.column    <= c.column;
        cmd_ch.direction <= c.direction;
        cmd_ch.index     <= c.index;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_lcd(c);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [7:0] value,
                           input logic ln, input logic [3:0] col, input logic dir,
                           input logic [4:0] idx);
        lcd_cmd_t c;
        c.operation = op;
        c.value     = value;
        c.line      = ln;
        c.column    = col;
        c.direction = dir;
        c.index     = idx;
        send_cmd(c);
    endtask

    // cache must read as spaces out of reset
    task automatic test_reset_state();
        send_op(OP_READ, 8'hFF, 1'b1, 4'hF, 1'b1, 5'd0);
        send_op(OP_READ, 8'h00, 1'b0, 4'h0, 1'b0, 5'd31);
    endtask

    // instruction, set cursor, char and read with field extremes, including the dropped code
    task automatic test_each_operation();
        send_op(OP_INSTR, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_INSTR, 8'hFF, 1'b1, 4'hF, 1'b1, 5'd31);
        send_op(OP_UNUSED, 8'hFF, 1'b1, 4'hF, 1'b1, 5'd31);
        send_op(OP_SETCUR, 8'h00, 1'b1, 4'hF, 1'b0, 5'd0);
        send_op(OP_CHAR, 8'hFF, 1'b0, 4'h0, 1'b0, 5'd0);
        // cursor now past the last column: next char wraps to line 0
        send_op(OP_CHAR, 8'h00, 1'b1, 4'hF, 1'b1, 5'd31);
        send_op(OP_READ, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_READ, 8'h00, 1'b0, 4'h0, 1'b0, 5'd31);
    endtask

    // shift across both ends of a line and from past the end
    task automatic test_cursor_edges();
        send_op(OP_SETCUR, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_SHIFT, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_SHIFT, 8'h00, 1'b0, 4'h0, 1'b1, 5'd0);
        send_op(OP_SHIFT, 8'h00, 1'b0, 4'h0, 1'b1, 5'd0);
        send_op(OP_SHIFT, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_SETCUR, 8'h00, 1'b1, 4'hF, 1'b0, 5'd0);
        send_op(OP_CHAR, 8'h41, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_SHIFT, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
    endtask

    // clear fills with nul, init with spaces
    task automatic test_clear_init();
        send_op(OP_CLEAR, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_READ, 8'h00, 1'b0, 4'h0, 1'b0, 5'd5);
        send_op(OP_CHAR, 8'h5A, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_READ, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_INIT, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
        send_op(OP_READ, 8'h00, 1'b0, 4'h0, 1'b0, 5'd0);
    endtask

    // receiver holds off while commands keep coming
    task automatic test_output_stall();
        int k;
        steady   = 1'b1;
        hold_req = HOLD_CYCLES;
        for (k = 0; k < 10; k++) send_op(OP_CHAR, 8'(8'h30 + k), 1'b0, 4'h0, 1'b0, 5'd0);
        steady = 1'b0;
    endtask

    // weighted random command mix, with a stretch at full rate
    task automatic test_random_mix();
        lcd_cmd_t c;
        int       sent;
        int       pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick        = $urandom_range(99);
            c.value     = 8'($urandom_range(255));
            c.line      = 1'($urandom_range(1));
            c.column    = 4'($urandom_range(15));
            c.direction = 1'($urandom_range(1));
            c.index     = 5'($urandom_range(31));
            if (pick < 40)      c.operation = OP_CHAR;
            else if (pick < 55) c.operation = OP_SHIFT;
            else if (pick < 65) c.operation = OP_SETCUR;
            else if (pick < 80) c.operation = OP_READ;
            else if (pick < 88) c.operation = OP_INSTR;
            else if (pick < 91) c.operation = OP_CLEAR;
            else if (pick < 93) c.operation = OP_INIT;
            else                c.operation = OP_UNUSED;
            if (c.operation != OP_UNUSED) sent++;
            steady = (sent >= 50 && sent < 80);
            send_cmd(c);
        end
        steady = 1'b0;
    endtask

    // ---------------- result side ----------------

    // receiver ready, with random idling and requested hold-offs
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result: sr_byte %h read_char %h", res_ch.sr_byte,
                       res_ch.read_char);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (res_ch.sr_byte !== want.sr_byte) begin
                    $error("sr_byte: expected %h, got %h", want.sr_byte, res_ch.sr_byte);
                    errors++;
                end
                if (res_ch.sr_valid !== want.sr_valid) begin
                    $error("sr_valid: expected %b, got %b", want.sr_valid, res_ch.sr_valid);
                    errors++;
                end
                if (res_ch.read_char !== want.read_char) begin
                    $error("read_char: expected %h, got %h", want.read_char,
                           res_ch.read_char);
                    errors++;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_char_lcd_nibble_writer: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        i_rst_n          = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = OP_CHAR;
        cmd_ch.value     = '0;
        cmd_ch.line      = 1'b0;
        cmd_ch.column    = '0;
        cmd_ch.direction = 1'b0;
        cmd_ch.index     = '0;
        fill_text(CHAR_SPACE);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_each_operation();
        test_cursor_edges();
        test_clear_init();
        test_output_stall();
        test_random_mix();

        cmd_ch.valid <= 1'b0;
        // drain, then allow for a stray late word
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("tb_char_lcd_nibble_writer: clean");
        end else begin
            $display("tb_char_lcd_nibble_writer: errors");
        end
        $finish;
    end

endmodule
